>>> src/keypad_code_lock_assert.svh
// Assertion macros shared by the keypad code lock modules.
// Each macro expects clk and rst_n in scope.
`ifndef KEYPAD_CODE_LOCK_ASSERT_SVH
`define KEYPAD_CODE_LOCK_ASSERT_SVH

`ifndef ASSERT_OFF

`define KCL_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("keypad_code_lock: forbidden condition seen");

`define KCL_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad_code_lock: implication failed");

`define KCL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad_code_lock: next-cycle check failed");

`else

`define KCL_ASSERT_NEVER(label, cond)
`define KCL_ASSERT_IMPLY(label, ante, cons)
`define KCL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> src/kcl_pkg.sv
package kcl_pkg;

    localparam int TICK_W     = 24;
    localparam int CODE_W     = 24;
    localparam int CODE_LEN_W = 3;
    localparam int DIGIT_W    = 4;
    localparam int CODE_SLOTS = CODE_W / DIGIT_W;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_CODE_DIGITS      = 2'd0;
    localparam logic [1:0] REG_CODE_LENGTH      = 2'd1;
    localparam logic [1:0] REG_KEY_DROP_TICKS   = 2'd2;
    localparam logic [1:0] REG_DOOR_CLOSE_TICKS = 2'd3;

    localparam logic [TICK_W-1:0] TICKS_RESET = TICK_W'(5000);

    localparam logic [DIGIT_W-1:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [DIGIT_W-1:0] KEY_ASTERISK  = 4'd10;
    localparam logic [DIGIT_W-1:0] KEY_POUND     = 4'd11;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_NONE  = 2'd0,
        VERDICT_ERROR = 2'd1,
        VERDICT_OPEN  = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        CODE_EV_NONE    = 2'd0,
        CODE_EV_BEEP    = 2'd1,
        CODE_EV_DROPPED = 2'd2,
        CODE_EV_WRONG   = 2'd3
    } code_event_t;

    typedef enum logic [1:0] {
        DOOR_EV_NONE    = 2'd0,
        DOOR_EV_OPENING = 2'd1,
        DOOR_EV_CLOSING = 2'd2
    } door_event_t;

    typedef struct packed {
        logic [CODE_W-1:0]     code_digits;
        logic [CODE_LEN_W-1:0] code_length;
        logic [TICK_W-1:0]     key_drop_ticks;
        logic [TICK_W-1:0]     door_close_ticks;
    } cfg_t;

    typedef struct packed {
        code_event_t code_event;
        door_event_t door_event;
        logic        door_open;
    } result_t;

endpackage

>>> src/kcl_regs.sv
module kcl_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kcl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [kcl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [kcl_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output kcl_pkg::cfg_t                  cfg
);
    import kcl_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_CODE_DIGITS:      cfg_next.code_digits      = pwdata[CODE_W-1:0];
                REG_CODE_LENGTH:      cfg_next.code_length      = pwdata[CODE_LEN_W-1:0];
                REG_KEY_DROP_TICKS:   cfg_next.key_drop_ticks   = pwdata[TICK_W-1:0];
                REG_DOOR_CLOSE_TICKS: cfg_next.door_close_ticks = pwdata[TICK_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_CODE_DIGITS:      prdata = APB_DATA_W'(cfg_reg.code_digits);
            REG_CODE_LENGTH:      prdata = APB_DATA_W'(cfg_reg.code_length);
            REG_KEY_DROP_TICKS:   prdata = APB_DATA_W'(cfg_reg.key_drop_ticks);
            REG_DOOR_CLOSE_TICKS: prdata = APB_DATA_W'(cfg_reg.door_close_ticks);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_digits      <= '0;
            cfg_reg.code_length      <= '0;
            cfg_reg.key_drop_ticks   <= TICKS_RESET;
            cfg_reg.door_close_ticks <= TICKS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> src/kcl_core.sv
`include "keypad_code_lock_assert.svh"

module kcl_core #(
    parameter int MAX_CODE_DIGITS = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          op,
    input  logic [kcl_pkg::DIGIT_W-1:0]   key,
    input  logic                          sound_busy,
    input  kcl_pkg::cfg_t                 cfg,
    output kcl_pkg::result_t              res
);
    import kcl_pkg::*;

    localparam int CNT_W = $clog2(MAX_CODE_DIGITS + 1);
    localparam int IDX_W = (MAX_CODE_DIGITS > 1) ? $clog2(MAX_CODE_DIGITS) : 1;
    localparam int LEN_W = (CNT_W > CODE_LEN_W) ? CNT_W : CODE_LEN_W;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CODE_DIGITS);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CODE_DIGITS);

    logic [DIGIT_W-1:0] digits_reg [MAX_CODE_DIGITS];
    logic [DIGIT_W-1:0] digits_next [MAX_CODE_DIGITS];
    logic [DIGIT_W-1:0] want [MAX_CODE_DIGITS];

    logic [CNT_W-1:0]  count_reg, count_next;
    verdict_t          verdict_reg, verdict_next;
    logic [TICK_W-1:0] entry_ticks_reg, entry_ticks_next;
    logic [TICK_W-1:0] door_ticks_reg, door_ticks_next;
    logic              door_open_reg, door_open_next;
    logic              digit_wr;
    logic [IDX_W-1:0]  wr_idx;

    logic [LEN_W-1:0]  code_len_ext;
    logic [LEN_W-1:0]  eff_len;
    logic              match;
    result_t           res_next;

    genvar g;
    generate
        for (g = 0; g < MAX_CODE_DIGITS; g++)
        begin : g_want
            if (g < CODE_SLOTS)
            begin : g_slot
                assign want[g] = cfg.code_digits[DIGIT_W*g +: DIGIT_W];
            end
            else
            begin : g_zero
                assign want[g] = '0;
            end
        end
    endgenerate

    assign code_len_ext = LEN_W'(cfg.code_length);
    assign eff_len      = (code_len_ext < MAX_LEN) ? code_len_ext : MAX_LEN;

    always_comb
    begin
        digit_wr = 1'b0;
        wr_idx   = count_reg[IDX_W-1:0];
        for (int i = 0; i < MAX_CODE_DIGITS; i++)
        begin
            digits_next[i] = digits_reg[i];
        end
        if (op == OP_KEY && verdict_reg == VERDICT_NONE && key <= KEY_DIGIT_MAX
            && cfg.code_length != '0 && count_reg < MAX_CNT)
        begin
            digit_wr = 1'b1;
            digits_next[wr_idx] = key;
        end
    end

    always_comb
    begin
        match = 1'b1;
        for (int i = 0; i < MAX_CODE_DIGITS; i++)
        begin
            if (LEN_W'(i) < eff_len && digits_next[i] != want[i])
            begin
                match = 1'b0;
            end
        end
    end

    always_comb
    begin
        count_next       = count_reg;
        verdict_next     = verdict_reg;
        entry_ticks_next = entry_ticks_reg;
        door_ticks_next  = door_ticks_reg;
        door_open_next   = door_open_reg;
        res_next.code_event = CODE_EV_NONE;
        res_next.door_event = DOOR_EV_NONE;

        if (op == OP_KEY)
        begin
            if (verdict_reg == VERDICT_NONE)
            begin
                if (key <= KEY_DIGIT_MAX && cfg.code_length != '0)
                begin
                    res_next.code_event = CODE_EV_BEEP;
                    if (digit_wr)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (LEN_W'(count_next) >= eff_len)
                    begin
                        verdict_next = match ? VERDICT_OPEN : VERDICT_ERROR;
                    end
                    entry_ticks_next = '0;
                end
                else if (key == KEY_ASTERISK)
                begin
                    entry_ticks_next = cfg.key_drop_ticks;
                end
                else if (key == KEY_POUND && cfg.code_length == '0)
                begin
                    verdict_next = VERDICT_OPEN;
                end
            end
        end
        else
        begin
            entry_ticks_next = (entry_ticks_reg == '1) ? entry_ticks_reg
                                                       : entry_ticks_reg + 1'b1;
            door_ticks_next  = (door_ticks_reg == '1) ? door_ticks_reg
                                                      : door_ticks_reg + 1'b1;
            if (door_open_reg && door_ticks_next >= cfg.door_close_ticks)
            begin
                door_open_next      = 1'b0;
                door_ticks_next     = '0;
                res_next.door_event = DOOR_EV_CLOSING;
            end
            if (!sound_busy)
            begin
                case (verdict_reg)
                    VERDICT_NONE:
                    begin
                        if (count_reg != '0 && entry_ticks_next >= cfg.key_drop_ticks)
                        begin
                            count_next          = '0;
                            entry_ticks_next    = '0;
                            res_next.code_event = CODE_EV_DROPPED;
                        end
                    end
                    VERDICT_ERROR:
                    begin
                        res_next.code_event = CODE_EV_WRONG;
                        count_next          = '0;
                        verdict_next        = VERDICT_NONE;
                    end
                    VERDICT_OPEN:
                    begin
                        door_open_next      = 1'b1;
                        door_ticks_next     = '0;
                        res_next.door_event = DOOR_EV_OPENING;
                        count_next          = '0;
                        verdict_next        = VERDICT_NONE;
                    end
                    default:
                    begin
                        count_next   = '0;
                        verdict_next = VERDICT_NONE;
                    end
                endcase
            end
        end
        res_next.door_open = door_open_next;
    end

    assign res = res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            verdict_reg     <= VERDICT_NONE;
            entry_ticks_reg <= '0;
            door_ticks_reg  <= '0;
            door_open_reg   <= 1'b0;
        end
        else if (step)
        begin
            count_reg       <= count_next;
            verdict_reg     <= verdict_next;
            entry_ticks_reg <= entry_ticks_next;
            door_ticks_reg  <= door_ticks_next;
            door_open_reg   <= door_open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && digit_wr)
        begin
            digits_reg[wr_idx] <= key;
        end
    end

    `KCL_ASSERT_NEVER(a_count_range, count_reg > MAX_CNT)
    `KCL_ASSERT_IMPLY(a_opening_state, res.door_event == DOOR_EV_OPENING, res.door_open)
    `KCL_ASSERT_NEXT(a_tick_clears_verdict, step && op == OP_TICK && !sound_busy,
                     verdict_reg == VERDICT_NONE)

endmodule

>>> src/keypad_code_lock.sv
// Keypad code lock.
// Input stream (s_*): one beat is a key press (s_tuser = 0) or a time tick
// (s_tuser = 1); s_tdata carries the key code and the sound-busy flag.
// Output stream (m_*): exactly one result beat per input beat, in order,
// carrying the code event, the door event and the door state after the beat.
// Configuration: APB-style port with the secret code, its length, the entry
// drop timeout and the door close delay; write only while the block is idle.
// A beat accepted into the input register loads the result register when it
// advances, once the result register is empty or being taken, and m_tvalid
// rises with that load. Throughput: one beat per cycle while m_tready is high;
// the state update between the input and result registers is combinational.
// Reset: the entry, verdict, both tick counters and the door state clear;
// the timeouts load 5000 ticks, the code and its length clear.
// Stall: while m_tready is low the result register holds; the input register
// still takes one more beat, then s_tready drops until the result is taken.
module keypad_code_lock #(
    parameter int MAX_CODE_DIGITS = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [3:0] key, [4] sound_busy
    input  logic                           s_tuser,  // [0] op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,  // [1:0] code_event, [3:2] door_event,
                                                     // [4] door_open
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kcl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [kcl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [kcl_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import kcl_pkg::*;

    cfg_t               cfg;
    result_t            core_res;
    result_t            out_res_reg;
    logic               in_valid_reg;
    logic               in_op_reg;
    logic [DIGIT_W-1:0] in_key_reg;
    logic               in_busy_reg;
    logic               out_valid_reg;
    logic               advance;
    logic               in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_res_reg.door_open, out_res_reg.door_event,
                       out_res_reg.code_event};

    kcl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kcl_core #(
        .MAX_CODE_DIGITS (MAX_CODE_DIGITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .op         (in_op_reg),
        .key        (in_key_reg),
        .sound_busy (in_busy_reg),
        .cfg        (cfg),
        .res        (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg   <= s_tuser;
            in_key_reg  <= s_tdata[3:0];
            in_busy_reg <= s_tdata[4];
        end
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    `KCL_ASSERT_IMPLY(a_ready_when_empty, !in_valid_reg, s_tready)
    `KCL_ASSERT_NEXT(a_result_follows, advance, m_tvalid)
    `KCL_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid)

endmodule
